>>> hw/rtl/rpm_to_timer_prescale_compare_macros.svh
// Assertion macros used by the top level of the speed-to-timer selector RTL.
`ifndef RPM_TO_TIMER_PRESCALE_COMPARE_MACROS_SVH
`define RPM_TO_TIMER_PRESCALE_COMPARE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define RPMTC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpmtc assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define RPMTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpmtc assertion failed");
`else
`define RPMTC_ASSERT_IMPL(label, ante, cons)
`define RPMTC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/rpmtc_pkg.sv
// Shared widths, codes and the prescaler shift table of the speed-to-timer selector.
`default_nettype none
package rpmtc_pkg;

  localparam int RPM_W  = 16;
  localparam int SPR_W  = 14;
  localparam int CLK_W  = 27;
  localparam int PROD_W = RPM_W + SPR_W;   // rpm * steps_per_rev
  localparam int DEN_W  = PROD_W + 1;      // times two toggles per step
  localparam int NUM_W  = CLK_W + 6;       // clock * 60
  localparam int CODE_W = 3;
  localparam int CMP_W  = 8;
  localparam int IDX_W  = 2;

  localparam int MUL_STEPS = SPR_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [CODE_W-1:0] PRESC_LAST = 3'd6;
  localparam logic [CMP_W-1:0]  COMPARE_LIMIT = 8'hFF;

  localparam logic [IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
  localparam logic [IDX_W-1:0] CFG_STEPS    = 2'd1;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 27'd16000000;
  localparam logic [SPR_W-1:0] STEPS_RESET    = 14'd200;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SEL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // Prescalers 1, 8, 32, 64, 128, 256 and 1024 are all powers of two,
  // so each one is a right shift of the unscaled quotient.
  function automatic logic [3:0] presc_shift(input logic [CODE_W-1:0] k);
    logic [3:0] s;
    case (k)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd8;
      3'd6:    s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rpmtc_mul.sv
// Bit-serial shift-add multiplier for rpm times steps per revolution.
`default_nettype none
module rpmtc_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rpmtc_pkg::RPM_W-1:0]   rpm,
  input  wire logic [rpmtc_pkg::SPR_W-1:0]   spr,
  output logic                               done,
  output logic [rpmtc_pkg::PROD_W-1:0]       product
);

  logic [rpmtc_pkg::PROD_W-1:0]    acc;
  logic [rpmtc_pkg::PROD_W-1:0]    acc_next;
  logic [rpmtc_pkg::SPR_W-1:0]     mr;
  logic [rpmtc_pkg::RPM_W-1:0]     md;
  logic [rpmtc_pkg::MUL_CNT_W-1:0] cnt;
  logic                            busy;

  // One multiplier bit per cycle, most significant bit first.
  always_comb begin
    acc_next = {acc[rpmtc_pkg::PROD_W-2:0], 1'b0};
    if (mr[rpmtc_pkg::SPR_W-1]) begin
      acc_next = acc_next + {{(rpmtc_pkg::PROD_W-rpmtc_pkg::RPM_W){1'b0}}, md};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= rpmtc_pkg::MUL_CNT_W'(rpmtc_pkg::MUL_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rpmtc_pkg::MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mr  <= spr;
      md  <= rpm;
    end else if (busy) begin
      acc <= acc_next;
      mr  <= {mr[rpmtc_pkg::SPR_W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule
`default_nettype wire

>>> hw/rtl/rpmtc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module rpmtc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rpmtc_pkg::NUM_W-1:0]   numer,
  input  wire logic [rpmtc_pkg::DEN_W-1:0]   denom,
  output logic                               done,
  output logic [rpmtc_pkg::NUM_W-1:0]        quot
);

  logic [rpmtc_pkg::DEN_W-1:0]     rem;
  logic [rpmtc_pkg::DEN_W-1:0]     d;
  logic [rpmtc_pkg::NUM_W-1:0]     qs;
  logic [rpmtc_pkg::DIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic [rpmtc_pkg::DEN_W:0]       trial;
  logic [rpmtc_pkg::DEN_W:0]       diff;
  logic                            ge;

  // The numerator shifts out of the top of qs while quotient bits enter below.
  always_comb begin
    trial = {rem, qs[rpmtc_pkg::NUM_W-1]};
    diff  = trial - {1'b0, d};
    ge    = (trial >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= rpmtc_pkg::DIV_CNT_W'(rpmtc_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rpmtc_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      d   <= denom;
      qs  <= numer;
    end else if (busy) begin
      rem <= ge ? diff[rpmtc_pkg::DEN_W-1:0] : trial[rpmtc_pkg::DEN_W-1:0];
      qs  <= {qs[rpmtc_pkg::NUM_W-2:0], ge};
    end
  end

  assign quot = qs;

endmodule
`default_nettype wire

>>> hw/rtl/rpm_to_timer_prescale_compare.sv
// Top level of the rpm to timer prescaler and compare value selector.
// A zero request or one with zero steps per revolution goes straight to the result stage; any
// other passes a 14-step serial multiply, a 33-step serial divide, then a scan of one
// prescaler per cycle. One request is in work at a time: the next request is taken only
// after the result is loaded, which a result stall holds off. Reset (synchronous, active high)
// restores 16 MHz and 200 steps, stops the timer and drops m_tvalid.
`default_nettype none
`include "rpm_to_timer_prescale_compare_macros.svh"
module rpm_to_timer_prescale_compare (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] rpm_request
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [2:0] prescaler_code, [10:3] compare_value,
                                      // [11] driver_enable, [12] no_fit, [15:13] zero
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index, // 0 cpu_clock_hz, 1 steps_per_rev
  input  wire logic [26:0] cfg_data
);

  rpmtc_pkg::state_t state;

  logic [rpmtc_pkg::CLK_W-1:0]  clock_hz;
  logic [rpmtc_pkg::SPR_W-1:0]  steps;

  logic [rpmtc_pkg::CODE_W-1:0] held_prescaler;
  logic [rpmtc_pkg::CMP_W-1:0]  held_compare;
  logic                         held_enable;
  logic                         miss;

  logic [rpmtc_pkg::CODE_W-1:0] out_code;
  logic [rpmtc_pkg::CMP_W-1:0]  out_compare;
  logic                         out_enable;
  logic                         out_miss;

  logic [rpmtc_pkg::CODE_W-1:0] k;
  logic [rpmtc_pkg::NUM_W-1:0]  numer;
  logic [rpmtc_pkg::PROD_W-1:0] product;
  logic [rpmtc_pkg::NUM_W-1:0]  quot;
  logic [rpmtc_pkg::NUM_W-1:0]  scaled;
  logic                         fit;
  logic                         mul_start;
  logic                         mul_done;
  logic                         div_start;
  logic                         div_done;
  logic                         in_xfer;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == rpmtc_pkg::ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;

  // Configuration registers; the user must send writes only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= rpmtc_pkg::CLOCK_HZ_RESET;
      steps    <= rpmtc_pkg::STEPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpmtc_pkg::CFG_CLOCK_HZ: clock_hz <= cfg_data;
        rpmtc_pkg::CFG_STEPS:    steps    <= cfg_data[rpmtc_pkg::SPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sixty times the clock as 64x minus 4x, which is one subtract.
  assign numer = {clock_hz, 6'b0} - {4'b0, clock_hz, 2'b0};

  // The multiplier starts on an accepted request that needs a division, and the
  // divider starts on the product the cycle the multiplier finishes.
  assign mul_start = in_xfer && (s_tdata != '0) && (steps != '0);
  assign div_start = (state == rpmtc_pkg::ST_MUL) && mul_done;

  rpmtc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .rpm     (s_tdata),
    .spr     (steps),
    .done    (mul_done),
    .product (product)
  );

  rpmtc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom ({product, 1'b0}),
    .done  (div_done),
    .quot  (quot)
  );

  // floor(N / (D * 2^s)) equals floor(N / D) shifted right by s, so a single
  // division serves every prescaler. The scan tries one prescaler per cycle.
  assign scaled = quot >> rpmtc_pkg::presc_shift(k);
  assign fit    = (scaled[rpmtc_pkg::NUM_W-1:rpmtc_pkg::CMP_W] == '0)
               && (scaled[rpmtc_pkg::CMP_W-1:0] != '0)
               && (scaled[rpmtc_pkg::CMP_W-1:0] != rpmtc_pkg::COMPARE_LIMIT);

  // Sequencer and held timer settings.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rpmtc_pkg::ST_IDLE;
      held_prescaler <= '0;
      held_compare   <= '0;
      held_enable    <= 1'b0;
      miss           <= 1'b0;
      k              <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // A taken result is dropped unless a new one is loaded in the same cycle.
      if (m_tready && (state != rpmtc_pkg::ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        rpmtc_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (s_tdata == '0) begin
              // Stop request: the compare value is kept and still reported.
              held_prescaler <= '0;
              held_enable    <= 1'b0;
              miss           <= 1'b0;
              state          <= rpmtc_pkg::ST_OUT;
            end else if (steps == '0) begin
              // Every divisor is zero, so nothing can fit.
              miss  <= 1'b1;
              state <= rpmtc_pkg::ST_OUT;
            end else begin
              state <= rpmtc_pkg::ST_MUL;
            end
          end
        end
        rpmtc_pkg::ST_MUL: begin
          if (mul_done) begin
            state <= rpmtc_pkg::ST_DIV;
          end
        end
        rpmtc_pkg::ST_DIV: begin
          if (div_done) begin
            k     <= '0;
            state <= rpmtc_pkg::ST_SEL;
          end
        end
        rpmtc_pkg::ST_SEL: begin
          if (fit) begin
            held_prescaler <= k + 1'b1;
            held_compare   <= scaled[rpmtc_pkg::CMP_W-1:0];
            held_enable    <= 1'b1;
            miss           <= 1'b0;
            state          <= rpmtc_pkg::ST_OUT;
          end else if (k == rpmtc_pkg::PRESC_LAST) begin
            miss  <= 1'b1;
            state <= rpmtc_pkg::ST_OUT;
          end else begin
            k <= k + 1'b1;
          end
        end
        rpmtc_pkg::ST_OUT: begin
          // The result register is loaded once the previous result has been taken.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= rpmtc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rpmtc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == rpmtc_pkg::ST_OUT) && (!m_tvalid || m_tready)) begin
      out_code    <= held_prescaler;
      out_compare <= held_compare;
      out_enable  <= held_enable;
      out_miss    <= miss;
    end
  end

  assign m_tdata = {3'b0, out_miss, out_enable, out_compare, out_code};

  // A running prescaler always comes with a compare value inside the fitting range.
  `RPMTC_ASSERT_IMPL(a_fit_range, m_tvalid && (out_code != '0), (out_compare != '0) && (out_compare != rpmtc_pkg::COMPARE_LIMIT))
  // The driver is on exactly when the timer clock is running.
  `RPMTC_ASSERT_IMPL(a_enable_code, m_tvalid, out_enable == (out_code != '0))
  // A request that needs a division moves straight into the multiply phase.
  `RPMTC_ASSERT_NEXT(a_start_mul, in_xfer && (s_tdata != '0) && (steps != '0), state == rpmtc_pkg::ST_MUL)
  // The divider only finishes while the sequencer waits for it.
  `RPMTC_ASSERT_IMPL(a_div_phase, div_done, state == rpmtc_pkg::ST_DIV)

endmodule
`default_nettype wire
